// ----- rtl/slpf_pkg.sv -----
// ----------------------------------------------------------------------------
// slpf_pkg
// Types and fixed widths shared by the status LED priority flasher.
// ----------------------------------------------------------------------------
`default_nettype none

package slpf_pkg;

    localparam int PATTERN_W = 28;
    localparam int PATTERNS  = 5;
    localparam int INDEX_W   = 3;
    localparam int MASK_W    = 5;
    localparam int COND_W    = 3;
    localparam int COUNT_W   = 4;
    localparam int POS_W     = 6;
    localparam int CODE_W    = 8;
    localparam int LEVEL_W   = 8;
    localparam int OP_W      = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    // pattern word layout
    localparam int RED_LSB   = 20;
    localparam int GREEN_LSB = 12;
    localparam int BLUE_LSB  = 4;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_COND  = 2'd1,
        OP_FAULT = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef logic [PATTERN_W-1:0] pattern_t;

    localparam pattern_t PATTERN_RESET [PATTERNS] = '{
        28'd327682, 28'd84049923, 28'd1285, 28'd83968004, 28'd83886080
    };

endpackage

`default_nettype wire

// ----- rtl/status_led_priority_flasher.sv -----
// ----------------------------------------------------------------------------
// status_led_priority_flasher
// Ranks raised conditions and flashes one RGB LED with the winner's pattern.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | content
//  s_*     | in        | s_tvalid / s_tready      | tuser: op, tdata: condition, raise, code
//  m_*     | out       | m_tvalid / m_tready      | tdata: red, green, blue, active_condition
//  cfg_*   | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data (pattern words)
//
//  One word in, one registered result word out, valid in the cycle after its word is
//  taken; a new word is taken every cycle while the result register is empty or being drained.
//  The rate is set by the single result register: state and result update
//  on the same edge. Beat phase and flash number are kept as counters
//  beside the beat position. Reset loads the default patterns and clears
//  all conditions; the LED is dark until the first tick.
//  A stalled result holds m_tdata and blocks input until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module status_led_priority_flasher #(
    parameter int TICKS_PER_BEAT  = 40,
    parameter int ON_TICKS        = 2,
    parameter int GAP_TICKS       = 2,
    parameter int MAX_FLASHES     = 9,
    parameter int CONDITIONS      = 5,
    parameter int FAULT_CONDITION = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [slpf_pkg::IN_DATA_W-1:0]     s_tdata,   // condition, raise, code, pad
    input  wire logic [slpf_pkg::OP_W-1:0]          s_tuser,   // op
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [slpf_pkg::OUT_DATA_W-1:0]         m_tdata,   // red, green, blue,
                                                               // active_condition, pad
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [slpf_pkg::INDEX_W-1:0]       cfg_index,
    input  wire logic [slpf_pkg::PATTERN_W-1:0]     cfg_data
);

    localparam int PERIOD = ON_TICKS + GAP_TICKS;

    slpf_pkg::pattern_t                  pattern_reg [slpf_pkg::PATTERNS];
    logic [slpf_pkg::MASK_W-1:0]         mask_reg, mask_next;
    logic [slpf_pkg::COUNT_W-1:0]        flash_code_reg, flash_code_next;
    logic [slpf_pkg::COND_W-1:0]         shown_cond_reg, shown_cond_next;
    logic [slpf_pkg::COUNT_W-1:0]        shown_count_reg, shown_count_next;
    logic [slpf_pkg::POS_W-1:0]          pos_reg, pos_next;
    logic [slpf_pkg::POS_W-1:0]          phase_reg, phase_next;
    logic [slpf_pkg::POS_W-1:0]          flash_reg, flash_next;
    logic [3*slpf_pkg::LEVEL_W-1:0]      level_reg, level_next;
    logic                                out_valid_reg;
    logic [slpf_pkg::OUT_DATA_W-1:0]     out_data_reg;

    logic                                fire;
    slpf_pkg::op_t                       op;
    logic [slpf_pkg::COND_W-1:0]         in_cond;
    logic                                in_raise;
    logic [slpf_pkg::CODE_W-1:0]         in_code;
    logic [slpf_pkg::COND_W-1:0]         win, win_after;
    slpf_pkg::pattern_t                  word;
    logic [slpf_pkg::COUNT_W-1:0]        count;
    logic [slpf_pkg::POS_W-1:0]          pos_eff, phase_eff, flash_eff;
    logic                                lit;

    assign fire      = s_tvalid && s_tready;
    assign s_tready  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign op       = slpf_pkg::op_t'(s_tuser);
    assign in_cond  = s_tdata[2:0];
    assign in_raise = s_tdata[3];
    assign in_code  = s_tdata[11:4];

    always_comb
    begin
        // winner before and after this word's mask update
        win = '0;
        for (int c = 1; c < CONDITIONS; c++)
        begin
            if (mask_reg[c])
                win = slpf_pkg::COND_W'(c);
        end

        word  = pattern_reg[win];
        count = word[slpf_pkg::COUNT_W-1:0];
        if (count == '0)
            count = flash_code_reg;
        if (count == '0)
            count = slpf_pkg::COUNT_W'(1);
        if (count > slpf_pkg::COUNT_W'(MAX_FLASHES))
            count = slpf_pkg::COUNT_W'(MAX_FLASHES);

        mask_next        = mask_reg;
        flash_code_next  = flash_code_reg;
        shown_cond_next  = shown_cond_reg;
        shown_count_next = shown_count_reg;
        pos_next         = pos_reg;
        phase_next       = phase_reg;
        flash_next       = flash_reg;
        level_next       = level_reg;
        pos_eff          = pos_reg;
        phase_eff        = phase_reg;
        flash_eff        = flash_reg;
        lit              = 1'b0;

        case (op)
            slpf_pkg::OP_TICK:
            begin
                // restart the beat on a new winner or count
                if (win != shown_cond_reg || count != shown_count_reg)
                begin
                    pos_eff   = '0;
                    phase_eff = '0;
                    flash_eff = '0;
                end
                shown_cond_next  = win;
                shown_count_next = count;
                lit = (flash_eff < slpf_pkg::POS_W'(count))
                      && (phase_eff < slpf_pkg::POS_W'(ON_TICKS));
                level_next = lit ? {word[slpf_pkg::BLUE_LSB  +: slpf_pkg::LEVEL_W],
                                    word[slpf_pkg::GREEN_LSB +: slpf_pkg::LEVEL_W],
                                    word[slpf_pkg::RED_LSB   +: slpf_pkg::LEVEL_W]}
                                 : '0;
                if (pos_eff + slpf_pkg::POS_W'(1) >= slpf_pkg::POS_W'(TICKS_PER_BEAT))
                begin
                    pos_next   = '0;
                    phase_next = '0;
                    flash_next = '0;
                end
                else
                begin
                    pos_next = pos_eff + slpf_pkg::POS_W'(1);
                    if (phase_eff + slpf_pkg::POS_W'(1) >= slpf_pkg::POS_W'(PERIOD))
                    begin
                        phase_next = '0;
                        flash_next = flash_eff + slpf_pkg::POS_W'(1);
                    end
                    else
                    begin
                        phase_next = phase_eff + slpf_pkg::POS_W'(1);
                        flash_next = flash_eff;
                    end
                end
            end
            slpf_pkg::OP_COND:
            begin
                if (in_cond != '0 && in_cond < slpf_pkg::COND_W'(CONDITIONS))
                    mask_next[in_cond] = in_raise;
            end
            slpf_pkg::OP_FAULT:
            begin
                if (in_code != '0)
                begin
                    flash_code_next = (in_code > slpf_pkg::CODE_W'(MAX_FLASHES))
                                      ? slpf_pkg::COUNT_W'(MAX_FLASHES)
                                      : in_code[slpf_pkg::COUNT_W-1:0];
                end
                if (FAULT_CONDITION < CONDITIONS)
                    mask_next[FAULT_CONDITION] = (in_code != '0);
            end
            default:
            begin
                mask_next = mask_reg;
            end
        endcase

        win_after = '0;
        for (int c = 1; c < CONDITIONS; c++)
        begin
            if (mask_next[c])
                win_after = slpf_pkg::COND_W'(c);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < slpf_pkg::PATTERNS; i++)
                pattern_reg[i] <= slpf_pkg::PATTERN_RESET[i];
            mask_reg        <= '0;
            flash_code_reg  <= '0;
            shown_cond_reg  <= '0;
            shown_count_reg <= '0;
            pos_reg         <= '0;
            phase_reg       <= '0;
            flash_reg       <= '0;
            level_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready
                && cfg_index < slpf_pkg::INDEX_W'(slpf_pkg::PATTERNS))
                pattern_reg[cfg_index] <= cfg_data;
            if (fire)
            begin
                mask_reg        <= mask_next;
                flash_code_reg  <= flash_code_next;
                shown_cond_reg  <= shown_cond_next;
                shown_count_reg <= shown_count_next;
                pos_reg         <= pos_next;
                phase_reg       <= phase_next;
                flash_reg       <= flash_next;
                level_reg       <= level_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_data_reg <= {5'b0, win_after, level_next};
    end

endmodule

`default_nettype wire

// ----- rtl/slpf_checker.sv -----
// ----------------------------------------------------------------------------
// slpf_checker
// Port-level checks for the status LED priority flasher.
// ----------------------------------------------------------------------------
`default_nettype none

module slpf_checker #(
    parameter int CONDITIONS = 5
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_tvalid,
    input wire logic                               s_tready,
    input wire logic [slpf_pkg::IN_DATA_W-1:0]     s_tdata,
    input wire logic [slpf_pkg::OP_W-1:0]          s_tuser,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [slpf_pkg::OUT_DATA_W-1:0]    m_tdata
);

    // a held result keeps its word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every accepted word yields a result on the next edge
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word produced no result");

    // an empty result register never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // the reported winner is at least as high as a raised condition
    a_raise: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == slpf_pkg::OP_COND && s_tdata[3]
        && s_tdata[2:0] != 3'd0 && s_tdata[2:0] < 3'(CONDITIONS)
        |=> m_tdata[26:24] >= $past(s_tdata[2:0]))
        else $error("raised condition not reflected");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[26:24] < 3'(CONDITIONS))
        else $error("active condition out of range");

endmodule

bind status_led_priority_flasher slpf_checker #(.CONDITIONS(CONDITIONS)) u_slpf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
